// ----- src/longest_distinct_run_length_assert.svh -----
// Assertion macros shared by the RTL. They use the clk and rst_n of the
// module that expands them.
`ifndef LONGEST_DISTINCT_RUN_LENGTH_ASSERT_SVH
`define LONGEST_DISTINCT_RUN_LENGTH_ASSERT_SVH

// Same-cycle implication.
`define LDRL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LDRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ldrl_pkg.sv -----
package ldrl_pkg;

  // Width of one input character.
  localparam int CODE_W = 8;

  // Width of the reported run length.
  localparam int LEN_W = 17;

endpackage

// ----- src/ldrl_if.sv -----
interface ldrl_in_if;
  logic                        valid;
  logic                        ready;
  logic [ldrl_pkg::CODE_W-1:0] char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ldrl_out_if;
  logic                       valid;
  logic                       ready;
  logic [ldrl_pkg::LEN_W-1:0] longest_length;
  logic                       too_long;

  modport source (output valid, output longest_length, output too_long, input ready);
  modport sink (input valid, input longest_length, input too_long, output ready);
endinterface

// ----- src/ldrl_pos_ram.sv -----
module ldrl_pos_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Read returns the old contents when the same entry is written in the
  // same cycle; the caller forwards around that.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/longest_distinct_run_length.sv -----
// Result: the last character moves from the stage-1 register to the output
// register, where its result stays until it is taken. Throughput: one character
// per cycle, set by the single read-modify-write stage on the position table with
// the previous write forwarded; a last character waits while a result is untaken.
// Reset: clears the valid marks, window, position, best length and handshake
// state at once; the position table itself is never cleared.
`include "longest_distinct_run_length_assert.svh"

module longest_distinct_run_length #(
  parameter int MAX_LEN       = 65536,
  parameter int ALPHABET_SIZE = 256
) (
  input logic        clk,
  input logic        rst_n,
  ldrl_in_if.sink    in_ch,
  ldrl_out_if.source out_ch
);

  localparam int AW     = $clog2(ALPHABET_SIZE);
  localparam int PW     = $clog2(MAX_LEN + 1);
  localparam int SW     = $clog2(MAX_LEN);
  localparam int CODE_N = 2 ** ldrl_pkg::CODE_W;

  // Character codes folded into the alphabet, built at elaboration.
  logic [AW-1:0] code_mod [CODE_N];

  for (genvar g = 0; g < CODE_N; g++) begin : g_code_mod
    assign code_mod[g] = AW'(g % ALPHABET_SIZE);
  end

  logic                     in_ready;
  logic                     in_acc;
  logic [AW-1:0]            in_code;

  logic                     s1_valid_r, s1_valid_nxt;
  logic [AW-1:0]            s1_code_r;
  logic                     s1_last_r;
  logic                     s1_adv;

  logic [ALPHABET_SIZE-1:0] seen_r, seen_nxt;
  logic [SW-1:0]            ws_r, ws_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [PW-1:0]            best_r, best_nxt;
  logic                     ovf_r, ovf_nxt;

  logic                     fwd_valid_r;
  logic [AW-1:0]            fwd_code_r;
  logic [SW-1:0]            fwd_pos_r;

  logic [SW-1:0]            rd_data;
  logic                     wr_en;

  logic                     in_range;
  logic [SW-1:0]            prev_pos;
  logic                     repeat_hit;
  logic [SW-1:0]            ws_item;
  logic [PW-1:0]            run_len;
  logic [PW-1:0]            best_item;

  logic                     out_valid_r, out_valid_nxt;
  logic [ldrl_pkg::LEN_W-1:0] out_len_r;
  logic                     out_too_long_r;

  assign in_code  = code_mod[in_ch.char_code];
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;

  assign in_range = pos_r < PW'(MAX_LEN);
  assign wr_en    = s1_adv && in_range;

  ldrl_pos_ram #(
    .DEPTH (ALPHABET_SIZE),
    .AW    (AW),
    .DW    (SW)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_code_r),
    .wr_data (pos_r[SW-1:0]),
    .rd_en   (in_acc),
    .rd_addr (in_code),
    .rd_data (rd_data)
  );

  always_comb begin
    // The last write may have landed in the same cycle as this item's read.
    prev_pos   = (fwd_valid_r && fwd_code_r == s1_code_r) ? fwd_pos_r : rd_data;
    repeat_hit = seen_r[s1_code_r] && (prev_pos >= ws_r);
    ws_item    = repeat_hit ? SW'(prev_pos + SW'(1)) : ws_r;
    run_len    = PW'(pos_r + PW'(1) - PW'(ws_item));
    best_item  = (run_len > best_r) ? run_len : best_r;

    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    seen_nxt      = seen_r;
    ws_nxt        = ws_r;
    pos_nxt       = pos_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (s1_adv) begin
      if (s1_last_r) begin
        seen_nxt      = '0;
        ws_nxt        = '0;
        pos_nxt       = '0;
        best_nxt      = '0;
        ovf_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else if (in_range) begin
        seen_nxt[s1_code_r] = 1'b1;
        ws_nxt              = ws_item;
        pos_nxt             = PW'(pos_r + PW'(1));
        best_nxt            = best_item;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      seen_r      <= '0;
      ws_r        <= '0;
      pos_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      seen_r      <= seen_nxt;
      ws_r        <= ws_nxt;
      pos_r       <= pos_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_code_r <= in_code;
      s1_last_r <= in_ch.last_char;
    end
    if (wr_en) begin
      fwd_code_r <= s1_code_r;
      fwd_pos_r  <= pos_r[SW-1:0];
    end
    if (s1_adv && s1_last_r) begin
      out_len_r      <= in_range ? ldrl_pkg::LEN_W'(best_item)
                                 : ldrl_pkg::LEN_W'(best_r);
      out_too_long_r <= ovf_r || !in_range;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.longest_length = out_len_r;
  assign out_ch.too_long       = out_too_long_r;

  `LDRL_ASSERT_IMPL(a_rslt_from_last, $rose(out_valid_r), $past(s1_valid_r && s1_last_r),
    "Result appeared without a last character")
  `LDRL_ASSERT_IMPL(a_ws_le_pos, 1'b1, PW'(ws_r) <= pos_r,
    "Window start is past the current position")
  `LDRL_ASSERT_IMPL(a_best_le_pos, 1'b1, best_r <= pos_r,
    "Best length exceeds the characters taken")
  `LDRL_ASSERT_NEXT(a_clear_on_last, s1_adv && s1_last_r,
    pos_r == '0 && best_r == '0 && seen_r == '0 && !ovf_r,
    "String state not cleared after the last character")

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 4;
  localparam int TEXT_MAX   = 65536;
  localparam int ALPHA      = 256;
  localparam int RAND_ITEMS = 1800;
  localparam int SCRIPT_LEN = 24;

  typedef struct packed {
    logic [ldrl_pkg::LEN_W-1:0] run_len;
    logic                       too_long;
  } run_result_t;

  typedef struct packed {
    logic [ldrl_pkg::CODE_W-1:0] code;
    logic                        is_last;
    logic                        typed;
    logic [ldrl_pkg::LEN_W-1:0]  run_len;
    logic                        too_long;
  } script_row_t;

  // Short strings with the classic answers. Only the trivial ones carry a typed result.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{8'h00, 1'b1, 1'b1, 17'd1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 17'd1, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b1, 1'b1, 17'd1, 1'b0},
    '{"a", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"c", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"a", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"c", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b1, 1'b0, 17'd0, 1'b0},
    '{"a", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"b", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"a", 1'b1, 1'b0, 17'd0, 1'b0},
    '{"t", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"m", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"m", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"z", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"u", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"x", 1'b0, 1'b0, 17'd0, 1'b0},
    '{"t", 1'b1, 1'b0, 17'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ldrl_in_if  in_ch ();
  ldrl_out_if out_ch ();

  longest_distinct_run_length #(
    .MAX_LEN      (TEXT_MAX),
    .ALPHABET_SIZE(ALPHA)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state for the string in flight.
  bit                         seen_mark [ALPHA];
  logic [15:0]                last_at   [ALPHA];
  logic [ldrl_pkg::LEN_W-1:0] win_lo;
  logic [ldrl_pkg::LEN_W-1:0] next_pos;
  logic [ldrl_pkg::LEN_W-1:0] best_run;
  bit                         overran;

  run_result_t pending_runs[$];

  int  errors;
  int  results_seen;
  int  strings_sent;
  int  bytes_sent;
  int  widest;
  bit  calm;

  function automatic void clear_string();
    foreach (seen_mark[i]) seen_mark[i] = 1'b0;
    win_lo   = '0;
    next_pos = '0;
    best_run = '0;
    overran  = 1'b0;
  endfunction

  // Advances the predictor by one byte; returns 1 when the byte closes a string.
  function automatic bit scan_char(input logic [ldrl_pkg::CODE_W-1:0] code,
                                   input logic is_last, output run_result_t res);
    logic [ldrl_pkg::LEN_W-1:0] run;
    res = '0;
    if (next_pos >= ldrl_pkg::LEN_W'(TEXT_MAX)) begin
      overran = 1'b1;
    end else begin
      if (seen_mark[code] && ldrl_pkg::LEN_W'(last_at[code]) >= win_lo) begin
        win_lo = ldrl_pkg::LEN_W'(last_at[code]) + ldrl_pkg::LEN_W'(1);
      end
      seen_mark[code] = 1'b1;
      last_at[code]   = next_pos[15:0];
      run = next_pos - win_lo + ldrl_pkg::LEN_W'(1);
      if (run > best_run) best_run = run;
      next_pos = next_pos + ldrl_pkg::LEN_W'(1);
    end
    if (!is_last) return 1'b0;
    res.run_len  = best_run;
    res.too_long = overran;
    clear_string();
    return 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  task automatic send_beat(input logic [ldrl_pkg::CODE_W-1:0] code, input logic is_last);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    in_ch.last_char <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic feed(input logic [ldrl_pkg::CODE_W-1:0] code, input logic is_last,
                      input bit typed = 1'b0, input run_result_t typed_res = '0);
    run_result_t res;
    send_beat(code, is_last);
    bytes_sent++;
    if (scan_char(code, is_last, res)) begin
      strings_sent++;
      if (int'(res.run_len) > widest) widest = int'(res.run_len);
      pending_runs.push_back(typed ? typed_res : res);
    end
  endtask

  // Holds the sender off until every reported length has been taken.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
  endtask

  task automatic make_text(ref logic [ldrl_pkg::CODE_W-1:0] text[$]);
    int                          mode;
    int                          n;
    int                          span;
    logic [ldrl_pkg::CODE_W-1:0] base;
    text.delete();
    mode = $urandom_range(0, 99);
    base = ldrl_pkg::CODE_W'($urandom_range(0, 255));
    if (mode < 45) begin
      // A narrow alphabet gives plenty of repeats inside the window.
      n    = $urandom_range(1, 12);
      span = $urandom_range(1, 6);
      repeat (n) text.push_back(ldrl_pkg::CODE_W'(base + $urandom_range(0, span - 1)));
    end else if (mode < 70) begin
      n = $urandom_range(1, 40);
      repeat (n) text.push_back(ldrl_pkg::CODE_W'($urandom_range(0, 255)));
    end else if (mode < 90) begin
      n = $urandom_range(2, 60);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 80) text.push_back(ldrl_pkg::CODE_W'(base + i));
        else text.push_back(ldrl_pkg::CODE_W'(base + $urandom_range(0, i)));
      end
    end else if (mode < 97) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: text.push_back(8'h00);
          1: text.push_back(8'hFF);
          2: text.push_back(8'h80);
          default: text.push_back(8'h7F);
        endcase
      end
    end else begin
      // Runs through the alphabet in order; strings of 256 bytes or more reach the length's ceiling.
      n = $urandom_range(250, 300);
      for (int i = 0; i < n; i++) text.push_back(ldrl_pkg::CODE_W'(base + i));
    end
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin : check_out
    run_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_runs.size() == 0) begin
        flag_error($sformatf("unexpected result length %0d too_long %0b",
                             out_ch.longest_length, out_ch.too_long));
      end else begin
        want = pending_runs.pop_front();
        results_seen++;
        if (out_ch.longest_length !== want.run_len) begin
          flag_error($sformatf("longest_length expected %0d, got %0d",
                               want.run_len, out_ch.longest_length));
        end
        if (out_ch.too_long !== want.too_long) begin
          flag_error($sformatf("too_long expected %0b, got %0b",
                               want.too_long, out_ch.too_long));
        end
      end
    end
  end

  initial begin : stimulus
    logic [ldrl_pkg::CODE_W-1:0] text[$];
    int                          rand_bytes;
    rand_bytes = 0;
    calm       = 1'b0;
    clear_string();
    foreach (last_at[i]) last_at[i] = '0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      feed(SCRIPT[i].code, SCRIPT[i].is_last, SCRIPT[i].typed,
           '{SCRIPT[i].run_len, SCRIPT[i].too_long});
    end
    drain();

    while (rand_bytes < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 15) calm = !calm;
      if ($urandom_range(0, 99) < 4) drain();
      make_text(text);
      foreach (text[i]) feed(text[i], i == text.size() - 1);
      rand_bytes += text.size();
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    $display("tb: %0d strings in %0d bytes, %0d results checked, longest run %0d",
             strings_sent, bytes_sent, results_seen, widest);
    $display("tb: narrow, random and full-alphabet strings, with idle gaps on both sides");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb: timeout with %0d results pending", pending_runs.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
